// ===== hdl/midpoint_line_rasterizer_unit_macros.svh =====
// Assertion macros used by the midpoint line rasterizer checker.
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MLR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("midpoint line rasterizer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("midpoint line rasterizer check failed");

`endif

// ===== hdl/mlr_pkg.sv =====
// Types, codes and octant mapping functions of the midpoint line rasterizer.
package mlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int STEP_BITS  = COORD_BITS + 2;
	localparam int DEC_BITS   = COORD_BITS + 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [STEP_BITS-1:0]  step_t;
	typedef logic signed [DEC_BITS-1:0]   dec_t;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef enum logic [2:0] {
		OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
	} oct_t;

	typedef struct packed {
		coord_t a;
		coord_t b;
	} pt_t;

	// Clamp the most negative code so every negation fits.
	function automatic coord_t sat_coord(coord_t v);
		coord_t r;
		r = v;
		if (v == {1'b1, {(COORD_BITS-1){1'b0}}})
			r = {1'b1, {(COORD_BITS-2){1'b0}}, 1'b1};
		return r;
	endfunction

	function automatic diff_t mag(diff_t v);
		return v[DIFF_BITS-1] ? -v : v;
	endfunction

	function automatic oct_t pick_octant(diff_t dx, diff_t dy);
		logic wide;
		oct_t o;
		wide = mag(dx) > mag(dy);
		if (!dx[DIFF_BITS-1] && !dy[DIFF_BITS-1])
			o = wide ? OCT_0 : OCT_1;
		else if (!dx[DIFF_BITS-1])
			o = wide ? OCT_7 : OCT_6;
		else if (dy[DIFF_BITS-1])
			o = wide ? OCT_4 : OCT_5;
		else
			o = wide ? OCT_3 : OCT_2;
		return o;
	endfunction

	function automatic pt_t to_zero(oct_t o, coord_t x, coord_t y);
		pt_t p;
		case (o)
			OCT_0: begin p.a = x;  p.b = y;  end
			OCT_1: begin p.a = y;  p.b = x;  end
			OCT_2: begin p.a = y;  p.b = -x; end
			OCT_3: begin p.a = -x; p.b = y;  end
			OCT_4: begin p.a = -x; p.b = -y; end
			OCT_5: begin p.a = -y; p.b = -x; end
			OCT_6: begin p.a = -y; p.b = x;  end
			default: begin p.a = x; p.b = -y; end
		endcase
		return p;
	endfunction

	// Result a holds x, b holds y.
	function automatic pt_t from_zero(oct_t o, coord_t a, coord_t b);
		pt_t p;
		case (o)
			OCT_0: begin p.a = a;  p.b = b;  end
			OCT_1: begin p.a = b;  p.b = a;  end
			OCT_2: begin p.a = -b; p.b = a;  end
			OCT_3: begin p.a = -a; p.b = b;  end
			OCT_4: begin p.a = -a; p.b = -b; end
			OCT_5: begin p.a = -b; p.b = -a; end
			OCT_6: begin p.a = b;  p.b = -a; end
			default: begin p.a = a; p.b = -b; end
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/midpoint_line_rasterizer_unit.sv =====
// Midpoint line rasterizer: eight-octant line walker, one pixel per request.
//
// Input channel (in_valid/in_ready): action 0 starts a line from start_x/y
// to end_x/y and emits the start pixel; action 1 advances one pixel along
// the active line. Output channel (out_valid/out_ready): one result per
// request, pixel_x/pixel_y in original coordinates, pixel_valid low for a
// step with no active line, last_pixel high on the line's end point.
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while the result is not stalled; the
// add, compare and octant remap of a step sit between those two registers,
// and the walker state is updated in the same cycle.
// When out_ready is low the result holds; the input register still takes
// one request, after which in_ready drops until the result is taken.
// Reset clears the line, both registers' valid bits and the octant; a step
// after reset gives an invalid result. A start during an active line
// drops the old line at once.
module midpoint_line_rasterizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  mlr_pkg::coord_t    start_x,
	input  mlr_pkg::coord_t    start_y,
	input  mlr_pkg::coord_t    end_x,
	input  mlr_pkg::coord_t    end_y,
	output logic               out_valid,
	input  logic               out_ready,
	output mlr_pkg::coord_t    pixel_x,
	output mlr_pkg::coord_t    pixel_y,
	output logic               pixel_valid,
	output logic               last_pixel
);
	import mlr_pkg::*;

	// input register
	logic   vld_s1;
	logic   act_s1;
	coord_t sx_s1, sy_s1, ex_s1, ey_s1;

	// walker state
	logic   active_q;
	oct_t   oct_q;
	coord_t wx_q, wy_q, wend_q;
	dec_t   dec_q;
	step_t  east_q, diag_q;

	// result register
	logic   out_valid_q;
	coord_t px_q, py_q;
	logic   pvld_q, last_q;

	logic   advance;
	coord_t sx, sy, ex, ey;
	diff_t  dx, dy, mx, my, dx0, dy0;
	logic   wide;
	oct_t   st_oct;
	pt_t    st_pt, en_pt;
	coord_t nx, ny;
	logic   take_diag;
	dec_t   ndec;
	logic   step_last;
	pt_t    pix;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !vld_s1 || advance;

	// start path
	always_comb begin
		sx     = sat_coord(sx_s1);
		sy     = sat_coord(sy_s1);
		ex     = sat_coord(ex_s1);
		ey     = sat_coord(ey_s1);
		dx     = diff_t'(ex) - diff_t'(sx);
		dy     = diff_t'(ey) - diff_t'(sy);
		mx     = mag(dx);
		my     = mag(dy);
		wide   = mx > my;
		dx0    = wide ? mx : my;
		dy0    = wide ? my : mx;
		st_oct = pick_octant(dx, dy);
		st_pt  = to_zero(st_oct, sx, sy);
		en_pt  = to_zero(st_oct, ex, ey);
	end

	// step path
	always_comb begin
		take_diag = !dec_q[DEC_BITS-1];
		nx        = wx_q + coord_t'(1);
		ny        = take_diag ? wy_q + coord_t'(1) : wy_q;
		ndec      = dec_q + (take_diag ? dec_t'(diag_q) : dec_t'(east_q));
		step_last = nx >= wend_q;
		pix       = from_zero(oct_q, nx, ny);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			oct_q       <= OCT_0;
			wx_q        <= '0;
			wy_q        <= '0;
			wend_q      <= '0;
			dec_q       <= '0;
			east_q      <= '0;
			diag_q      <= '0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (advance)
				out_valid_q <= vld_s1;
			if (advance && vld_s1) begin
				if (act_s1 == ACT_START) begin
					oct_q    <= st_oct;
					wx_q     <= st_pt.a;
					wy_q     <= st_pt.b;
					wend_q   <= en_pt.a;
					dec_q    <= (dec_t'(dy0) <<< 1) - dec_t'(dx0);
					east_q   <= step_t'(dy0) <<< 1;
					diag_q   <= step_t'(dy0 - dx0) <<< 1;
					active_q <= dx0 != '0;
				end else if (active_q) begin
					wx_q     <= nx;
					wy_q     <= ny;
					dec_q    <= ndec;
					active_q <= !step_last;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_s1 <= action;
			sx_s1  <= start_x;
			sy_s1  <= start_y;
			ex_s1  <= end_x;
			ey_s1  <= end_y;
		end
		if (advance && vld_s1) begin
			if (act_s1 == ACT_START) begin
				px_q   <= sx;
				py_q   <= sy;
				pvld_q <= 1'b1;
				last_q <= dx0 == '0;
			end else if (active_q) begin
				px_q   <= pix.a;
				py_q   <= pix.b;
				pvld_q <= 1'b1;
				last_q <= step_last;
			end else begin
				// no active line: drop the step
				px_q   <= '0;
				py_q   <= '0;
				pvld_q <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_valid = pvld_q;
	assign last_pixel  = last_q;

endmodule

// ===== hdl/mlr_checker.sv =====
// Port-level checks of the midpoint line rasterizer and their bind.
`include "midpoint_line_rasterizer_unit_macros.svh"

module mlr_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic            out_valid,
	input  logic            out_ready,
	input  mlr_pkg::coord_t pixel_x,
	input  mlr_pkg::coord_t pixel_y,
	input  logic            pixel_valid,
	input  logic            last_pixel
);
	import mlr_pkg::*;

	logic out_stall;
	logic idle_result;

	assign out_stall   = out_valid && !out_ready;
	assign idle_result = out_valid && !pixel_valid;

	// a stalled result holds until taken
	`MLR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_valid) && $stable(last_pixel))

	// a step without a line gives a zeroed result
	`MLR_ASSERT_IMP(a_idle_zero, idle_result, pixel_x == coord_t'(0) && pixel_y == coord_t'(0) && !last_pixel)

	// the input side only backs up behind a stalled result
	`MLR_ASSERT_IMP(a_ready_backpressure, !in_ready, out_valid && !out_ready)

	// a request waiting at the input never sees the result register empty and in_ready low
	`MLR_ASSERT_IMP(a_ready_when_empty, in_valid && !out_valid, in_ready)

endmodule

bind midpoint_line_rasterizer_unit mlr_checker u_mlr_checker (.*);
